/* rtl/core/flow_vector_to_color_wheel_core_macros.svh */
// Assertion helpers for the flow color wheel core.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef FLOW_VECTOR_TO_COLOR_WHEEL_CORE_MACROS_SVH
`define FLOW_VECTOR_TO_COLOR_WHEEL_CORE_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define FVCW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent holds later than the antecedent, delayed by dly.
`define FVCW_ASSERT_LATER(lbl, ante, dly, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##dly (cons)) else $error(msg);

`endif

/* rtl/core/fvcw_pkg.sv */
package fvcw_pkg;

    localparam int CORDIC_W    = 30;
    localparam int ATAN_COUNT  = 24;
    localparam int SQRT_STEPS  = 18;
    localparam int LEVEL_W     = 22;

    localparam logic [15:0] ANG_ZERO    = 16'd0;
    localparam logic [15:0] ANG_QUARTER = 16'd16384;
    localparam logic [15:0] ANG_HALF    = 16'd32768;
    localparam logic [15:0] ANG_3QUART  = 16'd49152;
    localparam logic [31:0] ANG_HALF_Z  = 32'h8000_0000;
    localparam logic [31:0] ROUND_HALF  = 32'h0000_8000;

    typedef logic [2:0] t_seg;

    localparam t_seg SEG_RED_MAGENTA  = 3'd0;
    localparam t_seg SEG_MAGENTA_BLUE = 3'd1;
    localparam t_seg SEG_BLUE_CYAN    = 3'd2;
    localparam t_seg SEG_CYAN_GREEN   = 3'd3;
    localparam t_seg SEG_GREEN_YELLOW = 3'd4;
    localparam t_seg SEG_YELLOW_RED   = 3'd5;

    localparam logic [31:0] ATAN_TURN [ATAN_COUNT] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680350,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41721,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Start level and slope of each segment, channels red, green, blue.
    localparam logic [7:0] LVL_FROM [6][3] = '{
        '{8'd255, 8'd0,   8'd0},
        '{8'd255, 8'd0,   8'd255},
        '{8'd64,  8'd64,  8'd255},
        '{8'd0,   8'd255, 8'd255},
        '{8'd0,   8'd255, 8'd0},
        '{8'd255, 8'd255, 8'd0}
    };

    localparam logic signed [8:0] LVL_DIFF [6][3] = '{
        '{9'sd0,    9'sd0,    9'sd255},
        '{-9'sd191, 9'sd64,   9'sd0},
        '{-9'sd64,  9'sd191,  9'sd0},
        '{9'sd0,    9'sd0,    -9'sd255},
        '{9'sd255,  9'sd0,    9'sd0},
        '{9'sd0,    -9'sd255, 9'sd0}
    };

endpackage

/* rtl/core/flow_vector_to_color_wheel_core.sv */
// Channel   Direction  Handshake              Payload
// command   in         start, busy            i_flow_x, i_flow_y (signed Q3.FRAC_BITS)
// result    out        o_strobe (one cycle)   o_red, o_green, o_blue
//
// One transaction is taken in every cycle; busy is always low.
// The 18-step square root pipeline or the CORDIC stage chain, whichever is
// longer, sets the pipeline depth between start and o_strobe; the shorter
// path is padded with delay stages.
// Reset clears only the valid bits that travel with the data.
// Results are shown for one cycle and the receiver cannot stall them.
`include "flow_vector_to_color_wheel_core_macros.svh"

module flow_vector_to_color_wheel_core #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS     = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [17:0] i_flow_x,
    input  logic signed [17:0] i_flow_y,
    output logic               o_strobe,
    output logic [7:0]         o_red,
    output logic [7:0]         o_green,
    output logic [7:0]         o_blue
);

    localparam int CW       = fvcw_pkg::CORDIC_W;
    localparam int SQRT_END = fvcw_pkg::SQRT_STEPS + 1;
    localparam int DEPTH    = (CORDIC_STAGES + 1 > SQRT_END + 1) ?
                              CORDIC_STAGES + 1 : SQRT_END + 1;
    localparam int RADW     = FRAC_BITS + 1;
    localparam int LW       = fvcw_pkg::LEVEL_W;
    localparam int PW       = RADW + LW;
    localparam int LAT      = DEPTH + 5;
    localparam logic [21:0] ONE_EXT = 22'(1) << FRAC_BITS;

    logic               r_in_vld;
    logic signed [17:0] r_in_x;
    logic signed [17:0] r_in_y;

    logic               r_vld [DEPTH];

    logic signed [35:0] n_sq_x;
    logic signed [35:0] n_sq_y;
    logic [34:0]        r_sq_x;
    logic [34:0]        r_sq_y;
    logic [35:0]        r_rem  [1:DEPTH-1];
    logic [35:0]        r_root [1:DEPTH-1];

    logic signed [CW-1:0] r_cx [DEPTH];
    logic signed [CW-1:0] r_cy [DEPTH];
    logic [31:0]          r_cz [DEPTH];
    logic                 r_spec   [DEPTH];
    logic [15:0]          r_spec_a [DEPTH];

    logic signed [CW-1:0] n_px;
    logic signed [CW-1:0] n_py;
    logic [31:0]          n_pz;
    logic                 n_pspec;
    logic [15:0]          n_pspec_a;

    logic [31:0]      n_zr;
    logic [15:0]      n_ang;
    logic [21:0]      n_root_ext;
    logic [21:0]      n_rad_ext;
    fvcw_pkg::t_seg   n_seg;
    logic [13:0]      n_off;

    logic             r_c1_vld;
    fvcw_pkg::t_seg   r_c1_seg;
    logic [13:0]      r_c1_off;
    logic [RADW-1:0]  r_c1_rad;

    logic [23:0]        n_base [3];
    logic signed [23:0] n_dprod [3];
    logic [23:0]        n_lsum [3];
    logic             r_c2_vld;
    logic [LW-1:0]    r_c2_lvl [3];
    logic [RADW-1:0]  r_c2_rad;

    logic             r_c3_vld;
    logic [PW-1:0]    r_c3_prod [3];

    logic [8:0]       n_q [3];
    logic [7:0]       n_pix [3];
    logic             r_c4_vld;
    logic [7:0]       r_red;
    logic [7:0]       r_green;
    logic [7:0]       r_blue;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
        r_in_x <= i_flow_x;
        r_in_y <= i_flow_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < DEPTH; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else begin
            r_vld[0] <= r_in_vld;
            for (int j = 1; j < DEPTH; j++) begin
                r_vld[j] <= r_vld[j-1];
            end
        end
    end

    // Radius path: squares, sum, then one root bit per stage.
    assign n_sq_x = r_in_x * r_in_x;
    assign n_sq_y = r_in_y * r_in_y;

    always_ff @(posedge i_clk) begin
        r_sq_x <= n_sq_x[34:0];
        r_sq_y <= n_sq_y[34:0];
    end

    for (genvar j = 1; j < DEPTH; j++) begin : g_rad
        if (j == 1) begin : g_sum
            always_ff @(posedge i_clk) begin
                r_rem[j]  <= 36'(r_sq_x) + 36'(r_sq_y);
                r_root[j] <= '0;
            end
        end else if (j <= SQRT_END) begin : g_sqrt
            localparam logic [35:0] BIT = 36'(1) << (2 * (SQRT_END - j));
            logic [35:0] n_trial;
            assign n_trial = r_root[j-1] + BIT;
            always_ff @(posedge i_clk) begin
                if (r_rem[j-1] >= n_trial) begin
                    r_rem[j]  <= r_rem[j-1] - n_trial;
                    r_root[j] <= (r_root[j-1] >> 1) + BIT;
                end else begin
                    r_rem[j]  <= r_rem[j-1];
                    r_root[j] <= r_root[j-1] >> 1;
                end
            end
        end else begin : g_pass
            always_ff @(posedge i_clk) begin
                r_rem[j]  <= r_rem[j-1];
                r_root[j] <= r_root[j-1];
            end
        end
    end

    // Angle path: axis cases and half-plane fold, then CORDIC vectoring.
    always_comb begin
        n_px      = CW'(r_in_x) <<< 8;
        n_py      = CW'(r_in_y) <<< 8;
        n_pz      = '0;
        n_pspec   = 1'b0;
        n_pspec_a = fvcw_pkg::ANG_ZERO;
        if (r_in_x == '0) begin
            n_pspec   = 1'b1;
            n_pspec_a = r_in_y[17] ? fvcw_pkg::ANG_3QUART : fvcw_pkg::ANG_QUARTER;
        end else if (r_in_y == '0) begin
            n_pspec   = 1'b1;
            n_pspec_a = r_in_x[17] ? fvcw_pkg::ANG_HALF : fvcw_pkg::ANG_ZERO;
        end
        if (r_in_x[17]) begin
            n_px = -(CW'(r_in_x) <<< 8);
            n_py = -(CW'(r_in_y) <<< 8);
            n_pz = fvcw_pkg::ANG_HALF_Z;
        end
    end

    for (genvar j = 0; j < DEPTH; j++) begin : g_ang
        if (j == 0) begin : g_prep
            always_ff @(posedge i_clk) begin
                r_cx[j]     <= n_px;
                r_cy[j]     <= n_py;
                r_cz[j]     <= n_pz;
                r_spec[j]   <= n_pspec;
                r_spec_a[j] <= n_pspec_a;
            end
        end else if (j <= CORDIC_STAGES) begin : g_rot
            logic signed [CW-1:0] n_xs;
            logic signed [CW-1:0] n_ys;
            assign n_xs = r_cx[j-1] >>> (j - 1);
            assign n_ys = r_cy[j-1] >>> (j - 1);
            always_ff @(posedge i_clk) begin
                if (!r_cy[j-1][CW-1]) begin
                    r_cx[j] <= r_cx[j-1] + n_ys;
                    r_cy[j] <= r_cy[j-1] - n_xs;
                    r_cz[j] <= r_cz[j-1] + fvcw_pkg::ATAN_TURN[j-1];
                end else begin
                    r_cx[j] <= r_cx[j-1] - n_ys;
                    r_cy[j] <= r_cy[j-1] + n_xs;
                    r_cz[j] <= r_cz[j-1] - fvcw_pkg::ATAN_TURN[j-1];
                end
                r_spec[j]   <= r_spec[j-1];
                r_spec_a[j] <= r_spec_a[j-1];
            end
        end else begin : g_pass
            always_ff @(posedge i_clk) begin
                r_cx[j]     <= r_cx[j-1];
                r_cy[j]     <= r_cy[j-1];
                r_cz[j]     <= r_cz[j-1];
                r_spec[j]   <= r_spec[j-1];
                r_spec_a[j] <= r_spec_a[j-1];
            end
        end
    end

    // Stage one of the color pipeline: round the angle, pick the segment, clamp.
    always_comb begin
        n_zr       = r_cz[DEPTH-1] + fvcw_pkg::ROUND_HALF;
        n_ang      = r_spec[DEPTH-1] ? r_spec_a[DEPTH-1] : n_zr[31:16];
        n_root_ext = 22'(r_root[DEPTH-1][17:0]);
        n_rad_ext  = (n_root_ext > ONE_EXT) ? ONE_EXT : n_root_ext;
        unique case (n_ang[15:14])
            2'b10:   n_seg = fvcw_pkg::SEG_GREEN_YELLOW;
            2'b11:   n_seg = fvcw_pkg::SEG_YELLOW_RED;
            default: n_seg = fvcw_pkg::t_seg'({1'b0, n_ang[14:13]});
        endcase
        n_off = n_ang[15] ? n_ang[13:0] : {n_ang[12:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        r_c1_seg <= n_seg;
        r_c1_off <= n_off;
        r_c1_rad <= n_rad_ext[RADW-1:0];
    end

    // Stage two: interpolated level of each channel in units of 2^-14.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_base[c]  = {2'b00, fvcw_pkg::LVL_FROM[r_c1_seg][c], 14'b0};
            n_dprod[c] = fvcw_pkg::LVL_DIFF[r_c1_seg][c] * $signed({1'b0, r_c1_off});
            n_lsum[c]  = n_base[c] + n_dprod[c];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_c2_lvl[c] <= n_lsum[c][LW-1:0];
        end
        r_c2_rad <= r_c1_rad;
    end

    // Stage three: radius times level.
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_c3_prod[c] <= PW'(r_c2_rad) * PW'(r_c2_lvl[c]);
        end
    end

    // Stage four: truncate and clip to eight bits.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_q[c]   = r_c3_prod[c][PW-1:FRAC_BITS+14];
            n_pix[c] = n_q[c][8] ? 8'hFF : n_q[c][7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_red   <= n_pix[0];
        r_green <= n_pix[1];
        r_blue  <= n_pix[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_vld <= 1'b0;
            r_c2_vld <= 1'b0;
            r_c3_vld <= 1'b0;
            r_c4_vld <= 1'b0;
        end else begin
            r_c1_vld <= r_vld[DEPTH-1];
            r_c2_vld <= r_c1_vld;
            r_c3_vld <= r_c2_vld;
            r_c4_vld <= r_c3_vld;
        end
    end

    assign o_strobe = r_c4_vld;
    assign o_red    = r_red;
    assign o_green  = r_green;
    assign o_blue   = r_blue;

    `FVCW_ASSERT_LATER(a_result_follows, start && !busy, LAT, o_strobe, "result strobe missing")
    `FVCW_ASSERT_NOW(a_no_stray_result, o_strobe, $past(start && !busy, LAT), "unexpected result")
    `FVCW_ASSERT_LATER(a_zero_is_black, start && !busy && i_flow_x == 0 && i_flow_y == 0, LAT, o_red == 0 && o_green == 0 && o_blue == 0, "zero vector not black")

endmodule
